// ===== rtl/jdc_pkg.sv =====
// Shared package of the Julian day number converter: types, pipeline depths,
// calendar constants and the month offset tables. Depends on nothing.
package jdc_pkg;

    localparam int FWD_STAGES = 3;
    localparam int REV_STAGES = 10;
    localparam int LATENCY    = FWD_STAGES + REV_STAGES;

    typedef enum logic {
        REQ_TO_JDN  = 1'b0,
        REQ_TO_DATE = 1'b1
    } t_req_kind;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;

    // The epoch offset of the date conversion with the constant 2 of the
    // Gregorian correction folded in.
    localparam logic [23:0] JDN_BASE        = 24'd1720997;
    localparam logic [23:0] NEG_YEAR_DAYS   = 24'd365;
    localparam logic [10:0] DAYS_4Y         = 11'd1461;
    localparam logic [22:0] GREG_SWITCH_JDN = 23'd2299161;
    localparam logic [24:0] E_OFFSET        = 25'd7468865;
    localparam logic [23:0] F_OFFSET        = 24'd1524;
    localparam logic [27:0] G_OFFSET        = 28'd2442;
    localparam logic [15:0] YEAR_BASE_LATE  = 16'd4716;
    localparam logic [15:0] YEAR_BASE_EARLY = 16'd4715;

    // Division by constants is done as multiplication by a rounded-up
    // reciprocal; each shift is large enough to be exact over the input range.
    localparam int          C_DIV   = 100;
    localparam int          C_SHIFT = 19;
    localparam logic [12:0] C_MULT  = 13'(((64'd1 << C_SHIFT) + C_DIV - 1) / C_DIV);

    localparam int          E_DIV   = 146097;
    localparam int          E_SHIFT = 43;
    localparam logic [25:0] E_MULT  = 26'(((64'd1 << E_SHIFT) + E_DIV - 1) / E_DIV);

    localparam int          G_DIV   = 7305;
    localparam int          G_SHIFT = 41;
    localparam logic [28:0] G_MULT  = 29'(((64'd1 << G_SHIFT) + G_DIV - 1) / G_DIV);

    localparam int          L_DIV   = 25;
    localparam int          L_SHIFT = 17;
    localparam logic [12:0] L_MULT  = 13'(((64'd1 << L_SHIFT) + L_DIV - 1) / L_DIV);

    typedef struct packed {
        t_req_kind   req_type;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [22:0] day_number;
    } t_req;

    typedef struct packed {
        logic vld;
        t_req req;
    } t_stage;

    typedef struct packed {
        logic        vld;
        logic [22:0] day_number;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        is_valid;
        logic        leap_year;
        logic [2:0]  weekday;
    } t_result;

    // Days before a month in the March-based year: (306001 * idx) / 10000.
    function automatic logic [8:0] mon_off(input logic [4:0] idx);
        logic [8:0] v;
        case (idx)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd489;
        endcase
        return v;
    endfunction

    // Month index (10000 * fh) / 306001, found by comparing against the
    // offsets; none of the exact quotients is an integer.
    function automatic logic [4:0] month_index(input logic [8:0] fh);
        logic [4:0] cnt;
        cnt = '0;
        for (int k = 1; k <= 16; k++) begin
            if (fh > mon_off(5'(k))) begin
                cnt = cnt + 5'd1;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/julian_day_date_converter_core.sv =====
// Top level of the Julian day number converter: command port, forward and
// reverse pipelines. Depends on jdc_pkg, jdc_fwd and jdc_rev.
//
// The core takes one conversion per clock cycle whenever start is high and
// busy is low; busy is high only while reset is asserted. Every transfer
// produces exactly one result (three stages for the date to day number
// path, ten for the day number to date path, which is traversed by both
// request types), shown for one cycle with o_strobe high.
// The receiver must take each result in that cycle; results leave in the
// order in which transfers were accepted.
module julian_day_date_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_req_type,
    input  logic [4:0]  i_day_in,
    input  logic [3:0]  i_month_in,
    input  logic [13:0] i_year_in,
    input  logic [22:0] i_day_number_in,
    output logic        busy,
    output logic        o_strobe,
    output logic [22:0] o_day_number_out,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic        o_is_valid,
    output logic        o_leap_year,
    output logic [2:0]  o_weekday
);

    jdc_pkg::t_stage  in_item;
    jdc_pkg::t_stage  mid_item;
    jdc_pkg::t_result res;

    assign busy = ~i_rst_n;

    always_comb begin
        in_item.vld            = start & ~busy;
        in_item.req.req_type   = jdc_pkg::t_req_kind'(i_req_type);
        in_item.req.day        = i_day_in;
        in_item.req.month      = i_month_in;
        in_item.req.year       = i_year_in;
        in_item.req.day_number = i_day_number_in;
    end

    jdc_fwd u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_item),
        .o_item  (mid_item)
    );

    jdc_rev u_rev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (mid_item),
        .o_res   (res)
    );

    assign o_strobe         = res.vld;
    assign o_day_number_out = res.day_number;
    assign o_day_out        = res.day;
    assign o_month_out      = res.month;
    assign o_year_out       = res.year;
    assign o_is_valid       = res.is_valid;
    assign o_leap_year      = res.leap_year;
    assign o_weekday        = res.weekday;

endmodule

// ===== rtl/jdc_fwd.sv =====
// Date to Julian day number pipeline, three register stages.
// Depends on jdc_pkg.
module jdc_fwd (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jdc_pkg::t_stage i_item,
    output jdc_pkg::t_stage o_item
);

    jdc_pkg::t_stage r_s1;
    jdc_pkg::t_stage r_s2;
    jdc_pkg::t_stage r_s3;
    logic            r_neg1;
    logic [26:0]     r_pcent;
    logic [24:0]     r_pa;
    logic [8:0]      r_b;
    logic [23:0]     r_a2;
    logic [23:0]     r_small2;

    logic            n_early;
    logic            n_neg;
    logic [13:0]     n_y2;
    logic [4:0]      n_m2p1;
    logic [26:0]     n_pcent;
    logic [24:0]     n_pa;
    logic [8:0]      n_b;
    logic [7:0]      n_cent;
    logic [23:0]     n_a2;
    logic [23:0]     n_small2;
    logic [23:0]     n_jdn;
    jdc_pkg::t_stage n_s3;

    always_comb begin
        n_early = (i_item.req.month == jdc_pkg::MONTH_JAN) ||
                  (i_item.req.month == jdc_pkg::MONTH_FEB);
        n_neg   = n_early && (i_item.req.year == 14'd0);
        n_y2    = n_early ? (n_neg ? 14'd0 : i_item.req.year - 14'd1) : i_item.req.year;
        n_m2p1  = n_early ? {1'b0, i_item.req.month} + 5'd13
                          : {1'b0, i_item.req.month} + 5'd1;
        n_pcent = 27'(n_y2) * 27'(jdc_pkg::C_MULT);
        n_pa    = 25'(n_y2) * 25'(jdc_pkg::DAYS_4Y);
        n_b     = jdc_pkg::mon_off(n_m2p1);
    end

    always_comb begin
        n_cent   = r_neg1 ? 8'd0 : r_pcent[jdc_pkg::C_SHIFT +: 8];
        n_a2     = r_neg1 ? (24'd0 - jdc_pkg::NEG_YEAR_DAYS) : {1'b0, r_pa[24:2]};
        n_small2 = jdc_pkg::JDN_BASE + 24'(r_s1.req.day) + 24'(r_b)
                 + 24'(n_cent[7:2]) - 24'(n_cent);
    end

    always_comb begin
        n_jdn = r_a2 + r_small2;
        n_s3  = r_s2;
        if (r_s2.req.req_type == jdc_pkg::REQ_TO_JDN) begin
            n_s3.req.day_number = n_jdn[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1   <= n_neg;
        r_pcent  <= n_pcent;
        r_pa     <= n_pa;
        r_b      <= n_b;
        r_a2     <= n_a2;
        r_small2 <= n_small2;
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_item;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
        end
    end

    assign o_item = r_s3;

endmodule

// ===== rtl/jdc_rev.sv =====
// Julian day number to date pipeline with validity, leap year and weekday,
// ten register stages. Depends on jdc_pkg.
module jdc_rev (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jdc_pkg::t_stage  i_item,
    output jdc_pkg::t_result o_res
);

    jdc_pkg::t_stage  r_pipe [jdc_pkg::REV_STAGES-1];
    logic [2:0]       r_wd   [jdc_pkg::REV_STAGES-1];
    logic             r_greg;
    logic [50:0]      r_pe;
    logic [23:0]      r_f2;
    logic [23:0]      r_f3;
    logic [27:0]      r_xg;
    logic [23:0]      r_f4;
    logic [56:0]      r_pg;
    logic [23:0]      r_f5;
    logic [14:0]      r_g5;
    logic [25:0]      r_ph;
    logic [14:0]      r_g6;
    logic [8:0]       r_fh6;
    logic [14:0]      r_g7;
    logic [8:0]       r_fh7;
    logic [4:0]       r_i7;
    logic [8:0]       r_dd;
    logic [4:0]       r_mm;
    logic [14:0]      r_yy;
    logic [4:0]       r_dd9;
    logic [3:0]       r_mm9;
    logic [14:0]      r_yy9;
    logic [27:0]      r_pl;
    logic             r_valid9;
    jdc_pkg::t_result r_res;

    logic             n_greg;
    logic [24:0]      n_xe;
    logic [50:0]      n_pe;
    logic [2:0]       n_wd;
    logic [7:0]       n_e;
    logic [23:0]      n_f2;
    logic [27:0]      n_xg;
    logic [56:0]      n_pg;
    logic [14:0]      n_g5;
    logic [25:0]      n_ph;
    logic [8:0]       n_fh6;
    logic [4:0]       n_i7;
    logic [8:0]       n_dd;
    logic [4:0]       n_mm;
    logic [15:0]      n_base;
    logic [15:0]      n_g16;
    logic [14:0]      n_yy;
    logic [27:0]      n_pl;
    logic             n_valid9;
    logic [10:0]      n_q25;
    logic             n_div25;
    jdc_pkg::t_result n_res;

    function automatic logic [2:0] mod7(input logic [23:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = '0;
        for (int k = 0; k < 8; k++) begin
            s1 = s1 + 6'(x[3*k +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
        return (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

    always_comb begin
        n_greg = i_item.req.day_number >= jdc_pkg::GREG_SWITCH_JDN;
        n_xe   = {i_item.req.day_number, 2'b00} - jdc_pkg::E_OFFSET;
        n_pe   = 51'(n_xe) * 51'(jdc_pkg::E_MULT);
        n_wd   = mod7({1'b0, i_item.req.day_number} + 24'd1);
    end

    always_comb begin
        n_e  = r_pe[jdc_pkg::E_SHIFT +: 8];
        n_f2 = r_greg ? 24'(r_pipe[0].req.day_number) + 24'd1 + 24'(n_e)
                        - 24'(n_e[7:2]) + jdc_pkg::F_OFFSET
                      : 24'(r_pipe[0].req.day_number) + jdc_pkg::F_OFFSET;
        n_xg = (28'(r_f2) << 4) + (28'(r_f2) << 2) - jdc_pkg::G_OFFSET;
        n_pg = 57'(r_xg) * 57'(jdc_pkg::G_MULT);
        n_g5 = r_pg[jdc_pkg::G_SHIFT +: 15];
        n_ph = 26'(n_g5) * 26'(jdc_pkg::DAYS_4Y);
        n_fh6 = 9'(r_f5 - r_ph[25:2]);
        n_i7 = jdc_pkg::month_index(r_fh6);
    end

    always_comb begin
        n_dd   = r_fh7 - jdc_pkg::mon_off(r_i7);
        n_mm   = (r_i7 < 5'd14) ? r_i7 - 5'd1 : r_i7 - 5'd13;
        n_base = (n_mm > 5'd2) ? jdc_pkg::YEAR_BASE_LATE : jdc_pkg::YEAR_BASE_EARLY;
        n_g16  = 16'(r_g7);
        n_yy   = 15'((n_g16 > n_base) ? n_g16 - n_base : n_base + 16'd1 - n_g16);
    end

    always_comb begin
        n_pl     = 28'(r_yy) * 28'(jdc_pkg::L_MULT);
        n_valid9 = (r_pipe[7].req.req_type == jdc_pkg::REQ_TO_DATE) ||
                   ((r_dd == 9'(r_pipe[7].req.day)) &&
                    (r_mm == 5'(r_pipe[7].req.month)) &&
                    (r_yy == 15'(r_pipe[7].req.year)));
    end

    always_comb begin
        n_q25            = r_pl[jdc_pkg::L_SHIFT +: 11];
        n_div25          = (15'(n_q25) * 15'(jdc_pkg::L_DIV)) == r_yy9;
        n_res.vld        = r_pipe[8].vld;
        n_res.day_number = r_pipe[8].req.day_number;
        n_res.day        = r_dd9;
        n_res.month      = r_mm9;
        n_res.year       = r_yy9[13:0];
        n_res.is_valid   = r_valid9;
        n_res.leap_year  = (r_yy9[1:0] == 2'd0) && (!n_div25 || (r_yy9[3:0] == 4'd0));
        n_res.weekday    = r_wd[8];
    end

    always_ff @(posedge i_clk) begin
        r_wd[0]   <= n_wd;
        for (int k = 1; k < jdc_pkg::REV_STAGES - 1; k++) begin
            r_wd[k]   <= r_wd[k-1];
        end
        r_greg   <= n_greg;
        r_pe     <= n_pe;
        r_f2     <= n_f2;
        r_f3     <= r_f2;
        r_xg     <= n_xg;
        r_f4     <= r_f3;
        r_pg     <= n_pg;
        r_f5     <= r_f4;
        r_g5     <= n_g5;
        r_ph     <= n_ph;
        r_g6     <= r_g5;
        r_fh6    <= n_fh6;
        r_g7     <= r_g6;
        r_fh7    <= r_fh6;
        r_i7     <= n_i7;
        r_dd     <= n_dd;
        r_mm     <= n_mm;
        r_yy     <= n_yy;
        r_dd9    <= r_dd[4:0];
        r_mm9    <= r_mm[3:0];
        r_yy9    <= r_yy;
        r_pl     <= n_pl;
        r_valid9 <= n_valid9;
        if (!i_rst_n) begin
            for (int k = 0; k < jdc_pkg::REV_STAGES - 1; k++) begin
                r_pipe[k] <= '0;
            end
            r_res <= '0;
        end else begin
            r_pipe[0] <= i_item;
            for (int k = 1; k < jdc_pkg::REV_STAGES - 1; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/jdc_checker.sv =====
// Port-level checker for the Julian day number converter and its bind.
// Depends on jdc_pkg and julian_day_date_converter_core.
module jdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        i_req_type,
    input logic [4:0]  i_day_in,
    input logic [3:0]  i_month_in,
    input logic [13:0] i_year_in,
    input logic [22:0] i_day_number_in,
    input logic        busy,
    input logic        o_strobe,
    input logic [22:0] o_day_number_out,
    input logic [4:0]  o_day_out,
    input logic [3:0]  o_month_out,
    input logic [13:0] o_year_out,
    input logic        o_is_valid,
    input logic        o_leap_year,
    input logic [2:0]  o_weekday
);

    localparam int LAT = jdc_pkg::LATENCY;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted transfer produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without a matching transfer");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |-> ##LAT
        (o_is_valid && (o_day_number_out == $past(i_day_number_in, LAT))))
        else $error("day number request not echoed as valid");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_day_out != 5'd0) && (o_month_out != 4'd0) &&
                     (o_month_out <= 4'd12) && (o_weekday <= 3'd6))
        else $error("result field out of range");

endmodule

bind julian_day_date_converter_core jdc_checker u_jdc_checker (.*);

// ===== sim/tb_julian_day_date_converter_core.sv =====
// Self-checking testbench of julian_day_date_converter_core: directed and random
// date and day number conversions checked against an in-bench calendar predictor.
// Depends on jdc_pkg and the core.
`timescale 1ns / 1ps

module tb_julian_day_date_converter_core;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [22:0] day_number;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        is_valid;
        logic        leap_year;
        logic [2:0]  weekday;
    } t_conv_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_req_type = 1'b0;
    logic [4:0]  i_day_in = '0;
    logic [3:0]  i_month_in = '0;
    logic [13:0] i_year_in = '0;
    logic [22:0] i_day_number_in = '0;
    logic        busy;
    logic        o_strobe;
    logic [22:0] o_day_number_out;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;
    logic        o_is_valid;
    logic        o_leap_year;
    logic [2:0]  o_weekday;

    t_conv_result expected_dates[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    julian_day_date_converter_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_req_type       (i_req_type),
        .i_day_in         (i_day_in),
        .i_month_in       (i_month_in),
        .i_year_in        (i_year_in),
        .i_day_number_in  (i_day_number_in),
        .busy             (busy),
        .o_strobe         (o_strobe),
        .o_day_number_out (o_day_number_out),
        .o_day_out        (o_day_out),
        .o_month_out      (o_month_out),
        .o_year_out       (o_year_out),
        .o_is_valid       (o_is_valid),
        .o_leap_year      (o_leap_year),
        .o_weekday        (o_weekday)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_conv_result convert_calendar(input jdc_pkg::t_req_kind kind,
            input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
            input logic [22:0] n);
        longint dl, ml, yl, y2, m2, cent, jdn, e, base, f, g, h, idx, dd, mm, yy, l;
        t_conv_result r;
        dl = d;
        ml = m;
        yl = y;
        if (kind == jdc_pkg::REQ_TO_JDN) begin
            y2 = yl;
            m2 = ml;
            if (m == jdc_pkg::MONTH_JAN || m == jdc_pkg::MONTH_FEB) begin
                y2 = yl - 1;
                m2 = ml + 12;
            end
            cent = y2 / 100;
            jdn = (1461 * y2) / 4 + (306001 * (m2 + 1)) / 10000 + 2 - cent + cent / 4
                  + dl + 1720995;
        end else begin
            jdn = n;
        end
        if (jdn < longint'(jdc_pkg::GREG_SWITCH_JDN)) begin
            base = jdn;
        end else begin
            e = (4 * jdn - 7468865) / 146097;
            base = jdn + 1 + e - e / 4;
        end
        f = base + 1524;
        g = (20 * f - 2442) / 7305;
        h = (1461 * g) / 4;
        idx = (10000 * (f - h)) / 306001;
        dd = f - h - (306001 * idx) / 10000;
        mm = (idx < 14) ? idx - 1 : idx - 13;
        l = (mm > 2) ? g - 4716 : g - 4715;
        yy = (l > 0) ? l : 1 - l;
        r.day_number = jdn[22:0];
        r.day        = dd[4:0];
        r.month      = mm[3:0];
        r.year       = yy[13:0];
        r.is_valid   = (kind == jdc_pkg::REQ_TO_JDN) ? (dd == dl && mm == ml && yy == yl)
                                                     : 1'b1;
        r.leap_year  = (yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0));
        r.weekday    = 3'((jdn + 1) % 7);
        return r;
    endfunction

    task automatic send_item(input jdc_pkg::t_req_kind kind, input logic [4:0] d,
            input logic [3:0] m, input logic [13:0] y, input logic [22:0] n);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            no_gaps = !no_gaps;
        end
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= kind;
        i_day_in        <= d;
        i_month_in      <= m;
        i_year_in       <= y;
        i_day_number_in <= n;
        do @(posedge i_clk); while (busy);
        expected_dates.insert(expected_dates.size(), convert_calendar(kind, d, m, y, n));
    endtask

    task automatic test_directed_extremes();
        send_item(jdc_pkg::REQ_TO_JDN, 5'd1, 4'd1, 14'd1, 23'h7FFFFF);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd31, 4'd12, 14'd9999, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd15, 4'd10, 14'd1582, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd4, 4'd10, 14'd1582, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd29, 4'd2, 14'd2000, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd29, 4'd2, 14'd1900, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd28, 4'd2, 14'd2100, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd0, 4'd0, 14'd0, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd31, 4'd15, 14'h3FFF, 23'h7FFFFF);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd0, 4'd1, 14'd0, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd1, 4'd2, 14'd0, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd31, 4'd1, 14'h3FFF, 23'd0);
        send_item(jdc_pkg::REQ_TO_JDN, 5'd30, 4'd13, 14'd2024, 23'd0);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd0);
        send_item(jdc_pkg::REQ_TO_DATE, 5'h1F, 4'hF, 14'h3FFF, 23'd2299160);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd2299161);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd5373484);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd5373485);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'h7FFFFF);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd2451545);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd1721423);
        send_item(jdc_pkg::REQ_TO_DATE, 5'd0, 4'd0, 14'd0, 23'd1721424);
    endtask

    task automatic test_random_dates(input int count);
        logic [13:0] y;
        logic [3:0]  m;
        int          mdays;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0:       y = 14'($urandom_range(10000, 16383));
                1:       y = 14'($urandom_range(1570, 1600));
                2:       y = 14'($urandom_range(1, 50));
                default: y = 14'($urandom_range(1, 9999));
            endcase
            m = 4'($urandom_range(1, 12));
            case (m)
                4'd2:                    mdays = (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0))
                                                 ? 29 : 28;
                4'd4, 4'd6, 4'd9, 4'd11: mdays = 30;
                default:                 mdays = 31;
            endcase
            send_item(jdc_pkg::REQ_TO_JDN, 5'($urandom_range(1, mdays)), m, y, 23'($urandom));
        end
    endtask

    task automatic test_random_day_numbers(input int count);
        logic [22:0] n;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 7))
                0:       n = 23'($urandom_range(0, 2000));
                1, 2:    n = 23'($urandom_range(2298161, 2300161));
                3:       n = 23'($urandom_range(5373485, 8388607));
                default: n = 23'($urandom_range(0, 5373484));
            endcase
            send_item(jdc_pkg::REQ_TO_DATE, 5'($urandom), 4'($urandom), 14'($urandom), n);
        end
    endtask

    task automatic test_raw_fields(input int count);
        for (int k = 0; k < count; k++) begin
            send_item(jdc_pkg::t_req_kind'($urandom_range(0, 1)), 5'($urandom), 4'($urandom),
                      14'($urandom), 23'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_conv_result exp_res;
        if (i_rst_n && o_strobe) begin
            if (expected_dates.size() == 0) begin
                $error("Result with no pending request: day_number %0d", o_day_number_out);
                mismatch_count++;
            end else begin
                exp_res = expected_dates.pop_front();
                if (o_day_number_out !== exp_res.day_number) begin
                    $error("day_number_out expected %0d actual %0d",
                           exp_res.day_number, o_day_number_out);
                    mismatch_count++;
                end
                if (o_day_out !== exp_res.day) begin
                    $error("day_out expected %0d actual %0d", exp_res.day, o_day_out);
                    mismatch_count++;
                end
                if (o_month_out !== exp_res.month) begin
                    $error("month_out expected %0d actual %0d", exp_res.month, o_month_out);
                    mismatch_count++;
                end
                if (o_year_out !== exp_res.year) begin
                    $error("year_out expected %0d actual %0d", exp_res.year, o_year_out);
                    mismatch_count++;
                end
                if (o_is_valid !== exp_res.is_valid) begin
                    $error("is_valid expected %0d actual %0d", exp_res.is_valid, o_is_valid);
                    mismatch_count++;
                end
                if (o_leap_year !== exp_res.leap_year) begin
                    $error("leap_year expected %0d actual %0d",
                           exp_res.leap_year, o_leap_year);
                    mismatch_count++;
                end
                if (o_weekday !== exp_res.weekday) begin
                    $error("weekday expected %0d actual %0d", exp_res.weekday, o_weekday);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_strobe)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("julian_day_date_converter_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_dates(450);
        test_random_day_numbers(400);
        test_raw_fields(250);
        start <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (jdc_pkg::LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0) begin
            $display("julian_day_date_converter_core test passed");
        end else begin
            $display("julian_day_date_converter_core test failed");
        end
        $finish;
    end

endmodule
